// ===== design/bac_pkg.sv =====
package bac_pkg;

  typedef enum logic [1:0] {
    MODE_LOCKED  = 2'd0,
    MODE_GRANTED = 2'd1,
    MODE_DENIED  = 2'd2,
    MODE_ACTIVE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_CARD    = 2'd1,
    FUNC_NO_CARD = 2'd2,
    FUNC_RST_BTN = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_SHORT = 2'd1,
    BEEP_LONG  = 2'd2
  } beep_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRANT_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENY_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RST_HOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP  = 3'd7;

  localparam logic [31:0] KEY_RESET        = 32'h56E3_00D9;
  localparam logic [15:0] GRANT_HOLD_RESET = 16'd1000;
  localparam logic [15:0] DENY_HOLD_RESET  = 16'd2000;
  localparam logic [15:0] IGNORE_RESET     = 16'd2000;
  localparam logic [15:0] BLINK_HALF_RESET = 16'd250;
  localparam logic [15:0] RST_HOLD_RESET   = 16'd250;
  localparam logic [15:0] SHORT_BEEP_RESET = 16'd500;
  localparam logic [15:0] LONG_BEEP_RESET  = 16'd2000;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] key_value;
    logic [15:0] grant_hold_ms;
    logic [15:0] deny_hold_ms;
    logic [15:0] ignore_window_ms;
    logic [15:0] blink_half_ms;
    logic [15:0] reset_holdoff_ms;
    logic [15:0] short_beep_ms;
    logic [15:0] long_beep_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        card_present;
    logic [63:0] seen_uid_low;
    logic [15:0] seen_uid_high;
    logic [3:0]  seen_length;
    logic [15:0] hold_timer;
    logic [15:0] ignore_timer;
    logic [15:0] beep_timer;
    logic [15:0] blink_count;
    logic        blink_on;
    logic [15:0] since_reset;
  } state_t;

  typedef struct packed {
    mode_t access_state;
    logic  red_led;
    logic  green_led;
    logic  blue_led;
    logic  denied_flag;
    beep_t beep_start;
    logic  card_acted;
  } result_t;

endpackage

// ===== design/bac_step.sv =====
module bac_step #(
  parameter int UID_MAX_BYTES = 10
) (
  input  bac_pkg::cfg_t    cfg,
  input  bac_pkg::state_t  cur,
  input  logic [1:0]       func,
  input  logic [63:0]      uid_low,
  input  logic [15:0]      uid_high,
  input  logic [3:0]       uid_len,
  output bac_pkg::state_t  nxt,
  output bac_pkg::result_t res
);

  localparam logic [3:0] MAX_LEN = 4'(UID_MAX_BYTES);

  logic [3:0]  len_c;
  logic [63:0] lo_mask;
  logic [15:0] hi_mask;
  logic [63:0] lo;
  logic [15:0] hi;
  logic        same;
  logic        match;
  logic [15:0] blink_inc;
  bac_pkg::beep_t beep;
  logic        acted;

  always_comb begin
    len_c = (uid_len > MAX_LEN) ? MAX_LEN : uid_len;
    for (int i = 0; i < 8; i++) begin
      lo_mask[8*i +: 8] = {8{len_c > 4'(i)}};
    end
    for (int i = 0; i < 2; i++) begin
      hi_mask[8*i +: 8] = {8{len_c > 4'(i + 8)}};
    end
    lo    = uid_low & lo_mask;
    hi    = uid_high & hi_mask;
    same  = cur.card_present && (len_c == cur.seen_length) &&
            (lo == cur.seen_uid_low) && (hi == cur.seen_uid_high);
    match = (len_c == 4'd4) && (lo[31:0] == cfg.key_value);
    blink_inc = cur.blink_count + 16'd1;
  end

  always_comb begin
    nxt   = cur;
    beep  = bac_pkg::BEEP_NONE;
    acted = 1'b0;
    case (bac_pkg::func_t'(func))
      bac_pkg::FUNC_TICK: begin
        if (cur.beep_timer != 16'd0) nxt.beep_timer = cur.beep_timer - 16'd1;
        if (cur.ignore_timer != 16'd0) nxt.ignore_timer = cur.ignore_timer - 16'd1;
        if (cur.since_reset != bac_pkg::TIMER_MAX) nxt.since_reset = cur.since_reset + 16'd1;
        if (cur.mode == bac_pkg::MODE_DENIED) begin
          if (blink_inc >= cfg.blink_half_ms) begin
            nxt.blink_count = 16'd0;
            nxt.blink_on    = ~cur.blink_on;
          end else begin
            nxt.blink_count = blink_inc;
          end
        end
        if (cur.mode == bac_pkg::MODE_GRANTED || cur.mode == bac_pkg::MODE_DENIED) begin
          if (cur.hold_timer <= 16'd1) begin
            nxt.hold_timer = 16'd0;
            nxt.mode = (cur.mode == bac_pkg::MODE_GRANTED) ? bac_pkg::MODE_ACTIVE
                                                           : bac_pkg::MODE_LOCKED;
          end else begin
            nxt.hold_timer = cur.hold_timer - 16'd1;
          end
        end
      end
      bac_pkg::FUNC_CARD: begin
        if (cur.beep_timer == 16'd0 && !same && cur.ignore_timer == 16'd0) begin
          nxt.seen_uid_low  = lo;
          nxt.seen_uid_high = hi;
          nxt.seen_length   = len_c;
          nxt.card_present  = 1'b1;
          acted = 1'b1;
          if (cur.mode == bac_pkg::MODE_ACTIVE) begin
            if (match) begin
              nxt.mode       = bac_pkg::MODE_LOCKED;
              nxt.beep_timer = cfg.short_beep_ms;
              beep = bac_pkg::BEEP_SHORT;
            end
          end else if (cur.mode == bac_pkg::MODE_LOCKED) begin
            if (match) begin
              nxt.mode         = bac_pkg::MODE_GRANTED;
              nxt.hold_timer   = cfg.grant_hold_ms;
              nxt.ignore_timer = cfg.ignore_window_ms;
              nxt.beep_timer   = cfg.short_beep_ms;
              beep = bac_pkg::BEEP_SHORT;
            end else begin
              nxt.mode        = bac_pkg::MODE_DENIED;
              nxt.hold_timer  = cfg.deny_hold_ms;
              nxt.blink_count = 16'd0;
              nxt.blink_on    = 1'b1;
              nxt.beep_timer  = cfg.long_beep_ms;
              beep = bac_pkg::BEEP_LONG;
            end
          end
        end
      end
      bac_pkg::FUNC_NO_CARD: begin
        if (cur.beep_timer == 16'd0) begin
          nxt.card_present  = 1'b0;
          nxt.seen_uid_low  = 64'd0;
          nxt.seen_uid_high = 16'd0;
          nxt.seen_length   = 4'd0;
        end
      end
      default: begin
        if (cur.since_reset > cfg.reset_holdoff_ms) begin
          nxt.since_reset = 16'd0;
          nxt.mode        = bac_pkg::MODE_LOCKED;
          nxt.hold_timer  = 16'd0;
        end
      end
    endcase
  end

  always_comb begin
    res.access_state = nxt.mode;
    res.red_led      = (nxt.mode == bac_pkg::MODE_LOCKED) ||
                       ((nxt.mode == bac_pkg::MODE_DENIED) && nxt.blink_on);
    res.green_led    = (nxt.mode == bac_pkg::MODE_GRANTED);
    res.blue_led     = (nxt.mode == bac_pkg::MODE_ACTIVE);
    res.denied_flag  = (nxt.mode == bac_pkg::MODE_DENIED);
    res.beep_start   = beep;
    res.card_acted   = acted;
  end

endmodule

// ===== design/badge_access_controller.sv =====
// The result of an accepted word is written to the output register.
// Throughput: one word per cycle while results are taken; the output register
// frees as it is taken, so a new word is accepted in the same cycle the previous
// result leaves. Reset (rst, synchronous): state cleared to locked, registers to
// defaults, output register empty.
module badge_access_controller #(
  parameter int UID_MAX_BYTES = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     func,
  input  logic [63:0]                    uid_low,
  input  logic [15:0]                    uid_high,
  input  logic [3:0]                     uid_len,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     access_state,
  output logic                           red_led,
  output logic                           green_led,
  output logic                           blue_led,
  output logic                           denied_flag,
  output logic [1:0]                     beep_start,
  output logic                           card_acted
);

  bac_pkg::cfg_t    cfg;
  bac_pkg::state_t  state;
  bac_pkg::state_t  state_next;
  bac_pkg::result_t res_next;
  bac_pkg::result_t res;
  logic             in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_value        <= bac_pkg::KEY_RESET;
      cfg.grant_hold_ms    <= bac_pkg::GRANT_HOLD_RESET;
      cfg.deny_hold_ms     <= bac_pkg::DENY_HOLD_RESET;
      cfg.ignore_window_ms <= bac_pkg::IGNORE_RESET;
      cfg.blink_half_ms    <= bac_pkg::BLINK_HALF_RESET;
      cfg.reset_holdoff_ms <= bac_pkg::RST_HOLD_RESET;
      cfg.short_beep_ms    <= bac_pkg::SHORT_BEEP_RESET;
      cfg.long_beep_ms     <= bac_pkg::LONG_BEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bac_pkg::REG_KEY:        cfg.key_value        <= cfg_data;
        bac_pkg::REG_GRANT_HOLD: cfg.grant_hold_ms    <= cfg_data[15:0];
        bac_pkg::REG_DENY_HOLD:  cfg.deny_hold_ms     <= cfg_data[15:0];
        bac_pkg::REG_IGNORE:     cfg.ignore_window_ms <= cfg_data[15:0];
        bac_pkg::REG_BLINK_HALF: cfg.blink_half_ms    <= cfg_data[15:0];
        bac_pkg::REG_RST_HOLD:   cfg.reset_holdoff_ms <= cfg_data[15:0];
        bac_pkg::REG_SHORT_BEEP: cfg.short_beep_ms    <= cfg_data[15:0];
        bac_pkg::REG_LONG_BEEP:  cfg.long_beep_ms     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bac_step #(
    .UID_MAX_BYTES(UID_MAX_BYTES)
  ) u_step (
    .cfg        (cfg),
    .cur        (state),
    .func       (func),
    .uid_low    (uid_low),
    .uid_high   (uid_high),
    .uid_len    (uid_len),
    .nxt        (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= bac_pkg::MODE_LOCKED;
      state.card_present  <= 1'b0;
      state.seen_uid_low  <= 64'd0;
      state.seen_uid_high <= 16'd0;
      state.seen_length   <= 4'd0;
      state.hold_timer    <= 16'd0;
      state.ignore_timer  <= 16'd0;
      state.beep_timer    <= 16'd0;
      state.blink_count   <= 16'd0;
      state.blink_on      <= 1'b1;
      state.since_reset   <= 16'd0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign access_state = res.access_state;
  assign red_led      = res.red_led;
  assign green_led    = res.green_led;
  assign blue_led     = res.blue_led;
  assign denied_flag  = res.denied_flag;
  assign beep_start   = res.beep_start;
  assign card_acted   = res.card_acted;

  // exactly one mode indicator per result
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({green_led, blue_led, denied_flag,
                           access_state == bac_pkg::MODE_LOCKED}))
    else $error("mode indicators not one-hot");

  a_beep_needs_card: assert property (@(posedge clk) disable iff (rst)
    out_valid && (beep_start != bac_pkg::BEEP_NONE) |-> card_acted)
    else $error("beep started without an evaluated card");

  // card words are dead while a beep sounds
  a_beep_blocks_card: assert property (@(posedge clk) disable iff (rst)
    in_fire && (func == bac_pkg::FUNC_CARD) && (state.beep_timer != 16'd0)
    |=> $stable(state) && !card_acted)
    else $error("card changed state during a beep");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    in_fire && (func == bac_pkg::FUNC_TICK) |=> state.since_reset != 16'd0)
    else $error("reset holdoff counter did not advance");

  a_locked_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && (access_state == bac_pkg::MODE_LOCKED) |-> red_led)
    else $error("red led off while locked");

endmodule
